/* design/hjb_pkg.sv */
// Shared types and constants for the hash join build and probe engine.
package hjb_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int MAX_BUCKET_BITS = 10;
    localparam int NUM_BUCKETS     = 1 << MAX_BUCKET_BITS;
    localparam int IDX_W           = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);
    localparam int BKT_W           = MAX_BUCKET_BITS;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;

    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_BUILD  = 2'd1;
    localparam t_op OP_PROBE  = 2'd2;
    localparam t_op OP_IGNORE = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_NOMATCH = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SKIP_BITS   = 2'd0;
    localparam t_cfg_idx CFG_BUCKET_BITS = 2'd1;
    localparam t_cfg_idx CFG_HASH_SIDE   = 2'd2;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] join_value;
        logic signed [31:0] row_key;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] first_key;
        logic signed [31:0] second_key;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [31:0]      value;
        logic [31:0]      key;
        logic [IDX_W-1:0] next;
        logic             next_valid;
        logic [BKT_W-1:0] bucket;
    } t_entry;

    typedef struct packed {
        logic    load_item;
        logic    head_rd;
        logic    ent_rd_head;
        logic    ent_rd_next;
        logic    build_wr;
        logic    clr;
        logic    pend_load;
        logic    out_load;
        logic    out_pair;
        logic    out_last;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic cur_ok;
        logic match;
        logic out_free;
        logic init_busy;
    } t_stat;

endpackage

/* design/hash_join_build_probe.sv */
// Top level of the bucket-chained hash join engine.
// Input channel: i_in_valid / o_in_ready carry one item (clear, build or probe).
// Result channel: o_out_valid / i_out_ready carry result items; the final
// result of each item has last set. Operation code 3 produces no result.
// Config channel: i_cfg_valid with index and data, always ready; write only
// while the engine is idle.
// One item is processed at a time. Steps of each item:
//   clear, or build into a full table: result load
//   build: bucket head read, entry read, link write
//   probe: bucket head read, entry read, then one chain entry per cycle,
//   except while a further match waits for a stalled receiver.
// A probe holds each match back until the next match or the chain end
// decides last.
// Reset clears the entry count, loads the default config and zeroes the
// 1024 bucket heads in a sweep with the input not ready; a head is then
// trusted only when it points below the entry count at an entry filed under
// the same bucket.
// A stalled receiver holds the result register; a probe pauses its chain
// walk at a further match until the pending result is transferred.
module hash_join_build_probe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hjb_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hjb_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hjb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hjb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hjb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hjb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hjb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register loaded while holding an untransferred result");

    a_build_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.build_wr |-> !stat.full)
        else $error("entry written into a full table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.operation != OP_IGNORE) |=> !o_in_ready)
        else $error("input ready while an item is in progress");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

/* design/hjb_ctrl.sv */
// Sequencing state machine for clear, build and chain-walking probe.
module hjb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hjb_pkg::t_op  i_in_op,
    output logic          o_in_ready,
    input  hjb_pkg::t_stat i_stat,
    output hjb_pkg::t_cmd o_cmd
);
    import hjb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_HEAD, S_ENTRY, S_EVAL} t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.init_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.init_busy) begin
                    o_cmd.load_item = 1'b1;
                    n_pend          = 1'b0;
                    if (i_in_op != OP_IGNORE) n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_stat.op == OP_CLEAR || (i_stat.op == OP_BUILD && i_stat.full)) begin
                    if (i_stat.out_free) begin
                        o_cmd.clr        = (i_stat.op == OP_CLEAR);
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = (i_stat.op == OP_CLEAR) ? ST_DONE : ST_FULL;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_ENTRY;
                end
            end
            S_ENTRY: begin
                o_cmd.ent_rd_head = 1'b1;
                n_state           = S_EVAL;
            end
            S_EVAL: begin
                priority if (i_stat.op == OP_BUILD) begin
                    if (i_stat.out_free) begin
                        o_cmd.build_wr   = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_DONE;
                        n_state          = S_IDLE;
                    end
                end else if (!i_stat.cur_ok) begin
                    // end of chain: flush held match or report no match
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_pair   = r_pend;
                        o_cmd.out_status = r_pend ? ST_DONE : ST_NOMATCH;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.match && r_pend) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load    = 1'b1;
                        o_cmd.out_pair    = 1'b1;
                        o_cmd.out_status  = ST_DONE;
                        o_cmd.pend_load   = 1'b1;
                        o_cmd.ent_rd_next = 1'b1;
                    end
                end else begin
                    o_cmd.ent_rd_next = 1'b1;
                    if (i_stat.match) begin
                        o_cmd.pend_load = 1'b1;
                        n_pend          = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

/* design/hjb_datapath.sv */
// Bucket head and entry memories, config registers, match logic and output register.
module hjb_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hjb_pkg::t_in_item        i_in,
    input  logic                     i_cfg_valid,
    input  logic [hjb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hjb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  hjb_pkg::t_cmd            i_cmd,
    output hjb_pkg::t_stat           o_stat,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output hjb_pkg::t_out_item       o_out
);
    import hjb_pkg::*;

    logic [4:0]       r_cfg_skip;
    logic [3:0]       r_cfg_bkt;
    logic             r_cfg_side;

    logic [IDX_W-1:0] head_mem [NUM_BUCKETS];
    t_entry           ent_mem  [TABLE_ENTRIES];

    t_in_item         r_item;
    logic [BKT_W-1:0] r_bucket;
    logic [IDX_W-1:0] r_hq;
    logic [IDX_W-1:0] r_cur;
    t_entry           r_ent;
    logic             r_first;
    logic             r_ok;
    logic [31:0]      r_pend_key;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             r_init;
    logic [BKT_W-1:0] r_init_addr;

    logic [31:0]      shifted;
    logic [BKT_W-1:0] mask;
    logic [BKT_W-1:0] in_bucket;
    logic             head_ok;
    logic             out_free;
    logic [IDX_W-1:0] ent_addr;

    assign shifted   = i_in.join_value >> r_cfg_skip;
    assign mask      = ~({BKT_W{1'b1}} << r_cfg_bkt);
    assign in_bucket = shifted[BKT_W-1:0] & mask;

    // a head is current only if its entry was filled since the last clear into this bucket
    assign head_ok  = (CNT_W'(r_cur) < r_count) && (r_ent.bucket == r_bucket);
    assign out_free = !r_out_valid || i_out_ready;
    assign ent_addr = i_cmd.ent_rd_head ? r_hq : r_ent.next;

    assign o_stat.op        = r_item.operation;
    assign o_stat.full      = (r_count >= CNT_W'(TABLE_ENTRIES));
    assign o_stat.cur_ok    = r_first ? head_ok : r_ok;
    assign o_stat.match     = (r_ent.value == r_item.join_value);
    assign o_stat.out_free  = out_free;
    assign o_stat.init_busy = r_init;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_skip <= 5'd0;
            r_cfg_bkt  <= 4'd6;
            r_cfg_side <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SKIP_BITS:   r_cfg_skip <= i_cfg_data[4:0];
                CFG_BUCKET_BITS: r_cfg_bkt  <= i_cfg_data[3:0];
                CFG_HASH_SIDE:   r_cfg_side <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // head sweep after reset, one bucket per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init) begin
            r_init_addr <= r_init_addr + BKT_W'(1);
            if (r_init_addr == BKT_W'(NUM_BUCKETS - 1)) r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) r_hq <= head_mem[r_bucket];
        if (r_init) head_mem[r_init_addr] <= '0;
        else if (i_cmd.build_wr) head_mem[r_bucket] <= r_count[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd_head || i_cmd.ent_rd_next) r_ent <= ent_mem[ent_addr];
        if (i_cmd.build_wr) begin
            ent_mem[r_count[IDX_W-1:0]] <= '{value:      r_item.join_value,
                                             key:        r_item.row_key,
                                             next:       r_cur,
                                             next_valid: head_ok,
                                             bucket:     r_bucket};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item   <= i_in;
            r_bucket <= in_bucket;
        end
        if (i_cmd.ent_rd_head) begin
            r_cur   <= r_hq;
            r_first <= 1'b1;
        end
        if (i_cmd.ent_rd_next) begin
            r_cur   <= r_ent.next;
            r_ok    <= r_ent.next_valid;
            r_first <= 1'b0;
        end
        if (i_cmd.pend_load) r_pend_key <= r_ent.key;
        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.out_status;
            r_out.last   <= i_cmd.out_last;
            if (i_cmd.out_pair) begin
                r_out.first_key  <= r_cfg_side ? r_item.row_key : r_pend_key;
                r_out.second_key <= r_cfg_side ? r_pend_key : r_item.row_key;
            end else begin
                r_out.first_key  <= '0;
                r_out.second_key <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_count <= '0;
            else if (i_cmd.build_wr) r_count <= r_count + CNT_W'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

endmodule
